// ----- rtl/mbd_pkg.sv -----
// Package for the multi-button debouncer: beat structs, request codes,
// register indexes and the per-lane result struct.
// No dependencies; every other file imports it.
package mbd_pkg;

   localparam int BTN_W  = 8;
   localparam int TIME_W = 32;
   localparam int CSR_W  = 32;

   // Request codes carried in the req_type field.
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_INIT   = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_DEBOUNCE_MS = 1'b0;
   localparam logic CSR_GUARD_MASK  = 1'b1;

   localparam logic [CSR_W-1:0] DEBOUNCE_MS_RESET = 32'd50;
   localparam logic [BTN_W-1:0] GUARD_MASK_RESET  = 8'd15;

   typedef struct packed {
      logic              req_type;
      logic [BTN_W-1:0]  raw_buttons;
      logic [TIME_W-1:0] now_ms;
   } mbd_req_type;

   typedef struct packed {
      logic [BTN_W-1:0] confirmed_buttons;
      logic [BTN_W-1:0] pressed_events;
      logic [BTN_W-1:0] released_events;
   } mbd_rsp_type;

   // What one lane proposes before the conflict check.
   typedef struct packed {
      logic state;
      logic pressed;
      logic released;
   } mbd_lane_out_type;

endpackage

// ----- rtl/mbd_lane.sv -----
// One button lane: raw-edge detection, change timer and stability compare.
// Depends on mbd_pkg.
module mbd_lane
   import mbd_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 update,
   input  logic                 init,
   input  logic                 raw_bit,
   input  logic [TIME_BITS-1:0] now,
   input  logic [CSR_W-1:0]     debounce_ms,
   input  logic                 final_state,
   output mbd_lane_out_type     lane_out
);

   localparam int CMP_W = (TIME_BITS > CSR_W) ? TIME_BITS : CSR_W;

   logic                 prev_raw_ff, prev_raw_in;
   logic                 state_ff, state_in;
   logic [TIME_BITS-1:0] stamp_ff, stamp_in;
   logic [TIME_BITS-1:0] stamp_eff;
   logic [TIME_BITS-1:0] elapsed;
   logic                 stable;

   always_comb begin
      stamp_eff = (raw_bit != prev_raw_ff) ? now : stamp_ff;
      elapsed   = now - stamp_eff;
      stable    = !(CMP_W'(elapsed) < CMP_W'(debounce_ms));

      lane_out.state    = state_ff;
      lane_out.pressed  = 1'b0;
      lane_out.released = 1'b0;
      if (init == REQ_INIT) begin
         lane_out.state = raw_bit;
      end else if (stable && (raw_bit != state_ff)) begin
         lane_out.state    = raw_bit;
         lane_out.pressed  = raw_bit;
         lane_out.released = !raw_bit;
      end

      prev_raw_in = update ? raw_bit : prev_raw_ff;
      state_in    = update ? final_state : state_ff;
      stamp_in    = stamp_ff;
      if (update) begin
         stamp_in = (init == REQ_INIT) ? now : stamp_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_raw_ff <= 1'b0;
         state_ff    <= 1'b0;
         stamp_ff    <= '0;
      end else begin
         prev_raw_ff <= prev_raw_in;
         state_ff    <= state_in;
         stamp_ff    <= stamp_in;
      end
   end

endmodule

// ----- rtl/mbd_merge.sv -----
// Merging stage: gathers the lane proposals, applies the movement conflict
// rule and forms the result beat. Depends on mbd_pkg.
module mbd_merge
   import mbd_pkg::*;
#(
   parameter int NUM_BUTTONS = 8
) (
   input  mbd_lane_out_type [NUM_BUTTONS-1:0] lane_out,
   input  logic                               init,
   input  logic [BTN_W-1:0]                   guard_mask,
   output logic [NUM_BUTTONS-1:0]             final_state,
   output mbd_rsp_type                        rsp
);

   logic [NUM_BUTTONS-1:0] state_v, press_v, release_v, mask_v, moves;
   logic                   conflict;

   always_comb begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         state_v[i]   = lane_out[i].state;
         press_v[i]   = lane_out[i].pressed;
         release_v[i] = lane_out[i].released;
      end
      mask_v = guard_mask[NUM_BUTTONS-1:0];
      moves  = state_v & mask_v;
      // More than one bit set among the guarded buttons is a conflict.
      conflict = (init != REQ_INIT) && ((moves & (moves - NUM_BUTTONS'(1))) != '0);
      if (conflict) begin
         state_v   = state_v & ~mask_v;
         press_v   = press_v & ~mask_v;
         release_v = release_v & ~mask_v;
      end
      final_state = state_v;

      rsp = '0;
      rsp.confirmed_buttons[NUM_BUTTONS-1:0] = state_v;
      rsp.pressed_events[NUM_BUTTONS-1:0]    = press_v;
      rsp.released_events[NUM_BUTTONS-1:0]   = release_v;
   end

endmodule

// ----- rtl/multi_button_debouncer_core.sv -----
// Top level of the multi-button debouncer: configuration registers, the
// button lanes, the merging stage and the result register.
// Depends on mbd_pkg, mbd_lane and mbd_merge.
//
// Usage:
//   Request channel (req_*): one beat holds a request code, a raw byte of
//   button levels and a millisecond timestamp. A sample request debounces;
//   an initialize request loads the state from the sample and stamps every
//   timer. Response channel (rsp_*): one beat per request with the
//   confirmed buttons and the pressed and released events of that step.
//   Configuration (csr_*): debounce time at index 0, movement mask at
//   index 1; write only while no request is in flight.
//   rsp_valid rises in the cycle after request acceptance. All lanes
//   work in parallel, so one request is taken every cycle; the single
//   result register sets the limit. When the receiver stalls, the result
//   register holds and req_ready drops until it is taken.
//   Synchronous reset clears all button state and timers and loads the
//   register defaults (50 ms, mask 0x0F).
module multi_button_debouncer_core
   import mbd_pkg::*;
#(
   parameter int NUM_BUTTONS = 8,
   parameter int TIME_BITS   = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mbd_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mbd_rsp_type       rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [CSR_W-1:0]  csr_wdata
);

   logic [CSR_W-1:0]       debounce_ff, debounce_in;
   logic [BTN_W-1:0]       guard_mask_ff, guard_mask_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   mbd_rsp_type            rsp_ff, rsp_in;
   logic                   accept;
   logic [TIME_BITS-1:0]   now_t;
   logic [NUM_BUTTONS-1:0] final_state;
   mbd_lane_out_type [NUM_BUTTONS-1:0] lane_out;
   mbd_rsp_type            merged;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign now_t     = TIME_BITS'(req_data.now_ms);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      debounce_in   = debounce_ff;
      guard_mask_in = guard_mask_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE_MS: debounce_in   = csr_wdata;
            CSR_GUARD_MASK:  guard_mask_in = csr_wdata[BTN_W-1:0];
            default: ;
         endcase
      end
   end

   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      mbd_lane #(
         .TIME_BITS (TIME_BITS)
      ) u_lane (
         .clock       (clock),
         .reset       (reset),
         .update      (accept),
         .init        (req_data.req_type),
         .raw_bit     (req_data.raw_buttons[i]),
         .now         (now_t),
         .debounce_ms (debounce_ff),
         .final_state (final_state[i]),
         .lane_out    (lane_out[i])
      );
   end

   mbd_merge #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_merge (
      .lane_out    (lane_out),
      .init        (req_data.req_type),
      .guard_mask  (guard_mask_ff),
      .final_state (final_state),
      .rsp         (merged)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_in       = merged;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_MS_RESET;
         guard_mask_ff <= GUARD_MASK_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         debounce_ff   <= debounce_in;
         guard_mask_ff <= guard_mask_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   a_accept_gives_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no response beat");

   a_events_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.pressed_events & rsp_ff.released_events) == '0))
      else $error("button both pressed and released in one beat");

   a_press_is_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.pressed_events & ~rsp_ff.confirmed_buttons) == '0))
      else $error("pressed event on a button that is not confirmed");

   a_release_is_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.released_events & rsp_ff.confirmed_buttons) == '0))
      else $error("released event on a button that is still confirmed");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("request stalled with an empty result register");
`endif

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for multi_button_debouncer_core: directed and random
// sample/initialize traffic with bursty sending and a stalling receiver.
// Depends on mbd_pkg and the RTL of the debouncer core.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mbd_pkg::*;

   typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_RHYTHM} rx_mode_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   mbd_req_type       req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   mbd_rsp_type       rsp_data;
   logic              csr_we    = 1'b0;
   logic              csr_index = CSR_DEBOUNCE_MS;
   logic [CSR_W-1:0]  csr_wdata = '0;

   // Predictor copy of the block's registers and button state.
   logic [CSR_W-1:0]  cfg_debounce;
   logic [BTN_W-1:0]  cfg_guard_mask;
   logic [BTN_W-1:0]  last_raw;
   logic [BTN_W-1:0]  held_state;
   logic [TIME_W-1:0] change_stamp [BTN_W];

   mbd_rsp_type       pending_rsp [$];
   int                error_count = 0;
   int                hold_left   = 0;
   int                burst_left  = 0;
   logic [TIME_W-1:0] stim_time   = '0;
   logic [BTN_W-1:0]  stim_raw    = '0;

   multi_button_debouncer_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= 40) begin
         $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
      end
   endtask

   function automatic void clear_model();
      cfg_debounce   = DEBOUNCE_MS_RESET;
      cfg_guard_mask = GUARD_MASK_RESET;
      last_raw       = '0;
      held_state     = '0;
      for (int i = 0; i < BTN_W; i++) begin
         change_stamp[i] = '0;
      end
   endfunction

   // Computes the response to one request and advances the button state.
   function automatic mbd_rsp_type debounce_step(input mbd_req_type beat);
      mbd_rsp_type       res;
      logic [BTN_W-1:0]  changed;
      logic [BTN_W-1:0]  pressed;
      logic [BTN_W-1:0]  released;
      logic [TIME_W-1:0] elapsed;
      pressed  = '0;
      released = '0;
      if (beat.req_type == REQ_INIT) begin
         for (int i = 0; i < BTN_W; i++) begin
            change_stamp[i] = beat.now_ms;
         end
         held_state = beat.raw_buttons;
         last_raw   = beat.raw_buttons;
      end else begin
         changed  = beat.raw_buttons ^ last_raw;
         last_raw = beat.raw_buttons;
         for (int i = 0; i < BTN_W; i++) begin
            if (changed[i]) begin
               change_stamp[i] = beat.now_ms;
            end
            elapsed = beat.now_ms - change_stamp[i];
            if (elapsed >= cfg_debounce && beat.raw_buttons[i] != held_state[i]) begin
               held_state[i] = beat.raw_buttons[i];
               if (beat.raw_buttons[i]) begin
                  pressed[i] = 1'b1;
               end else begin
                  released[i] = 1'b1;
               end
            end
         end
         // Two or more confirmed movement buttons cancel each other out.
         if ($countones(held_state & cfg_guard_mask) > 1) begin
            held_state = held_state & ~cfg_guard_mask;
            pressed    = pressed & ~cfg_guard_mask;
            released   = released & ~cfg_guard_mask;
         end
      end
      res.confirmed_buttons = held_state;
      res.pressed_events    = pressed;
      res.released_events   = released;
      return res;
   endfunction

   // Register writes, accepted requests and returned responses, all seen at the
   // rising edge; a request is predicted before a response is popped.
   always @(posedge clock) begin : monitor
      mbd_rsp_type want;
      if (reset) begin
         clear_model();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_DEBOUNCE_MS) begin
               cfg_debounce = csr_wdata;
            end else begin
               cfg_guard_mask = csr_wdata[BTN_W-1:0];
            end
         end
         if (req_valid && req_ready) begin
            pending_rsp.push_back(debounce_step(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch("response beat with nothing pending",
                               rsp_data.confirmed_buttons, 0);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.confirmed_buttons !== want.confirmed_buttons) begin
                  report_mismatch("confirmed_buttons", rsp_data.confirmed_buttons,
                                  want.confirmed_buttons);
               end
               if (rsp_data.pressed_events !== want.pressed_events) begin
                  report_mismatch("pressed_events", rsp_data.pressed_events,
                                  want.pressed_events);
               end
               if (rsp_data.released_events !== want.released_events) begin
                  report_mismatch("released_events", rsp_data.released_events,
                                  want.released_events);
               end
            end
         end
      end
   end

   // Receiver: switches among stall patterns, and honors a requested hold-off.
   initial begin : rsp_pacer
      rx_mode_type mode;
      int          mode_left;
      mode      = RX_OPEN;
      mode_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (mode)
               RX_OPEN:   rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               RX_MOSTLY: rsp_ready <= ($urandom_range(0, 7) != 0);
               default:   rsp_ready <= (mode_left % 5 != 0);
            endcase
         end
      end
   end

   task automatic send_beat(input mbd_req_type beat);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_req(input logic code, input logic [BTN_W-1:0] raw,
                           input logic [TIME_W-1:0] stamp);
      mbd_req_type beat;
      beat.req_type    = code;
      beat.raw_buttons = raw;
      beat.now_ms      = stamp;
      send_beat(beat);
   endtask

   task automatic idle_cycles(input int count);
      repeat (count) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic pace_sender();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         idle_cycles($urandom_range(1, 8));
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_drained();
      idle_cycles(1);
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [CSR_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Mostly steady levels, single-button flips and time steps near the debounce
   // time, so buttons really get confirmed; the rest is noise and re-initialization.
   function automatic mbd_req_type next_sample(input logic [CSR_W-1:0] dbc);
      mbd_req_type beat;
      int          roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         stim_time = stim_time + $urandom_range(0, 3);
      end else if (roll < 85) begin
         stim_time = stim_time + dbc + $urandom_range(0, 4) - 2;
      end else begin
         stim_time = $urandom;
      end
      roll = $urandom_range(0, 99);
      if (roll >= 55 && roll < 82) begin
         stim_raw = stim_raw ^ BTN_W'(1 << $urandom_range(0, BTN_W - 1));
      end else if (roll >= 82) begin
         stim_raw = BTN_W'($urandom_range(0, 255));
      end
      beat.req_type    = ($urandom_range(0, 29) == 0) ? REQ_INIT : REQ_SAMPLE;
      beat.raw_buttons = stim_raw;
      beat.now_ms      = stim_time;
      return beat;
   endfunction

   task automatic test_reset_defaults();
      send_req(REQ_SAMPLE, 8'h00, 32'd0);
      send_req(REQ_SAMPLE, 8'h01, 32'd10);
      send_req(REQ_SAMPLE, 8'h01, 32'd59);
      send_req(REQ_SAMPLE, 8'h01, 32'd60);
      send_req(REQ_SAMPLE, 8'h00, 32'd200);
      send_req(REQ_SAMPLE, 8'h00, 32'd250);
   endtask

   // Initialize at the top of the time range, then confirm across the wrap.
   task automatic test_init_and_wrap();
      send_req(REQ_INIT,   8'hFF, 32'hFFFF_FFFF);
      send_req(REQ_INIT,   8'h00, 32'hFFFF_FFF0);
      send_req(REQ_SAMPLE, 8'h10, 32'hFFFF_FFF8);
      send_req(REQ_SAMPLE, 8'h10, 32'h0000_002A);
   endtask

   task automatic test_zero_debounce_conflict();
      write_csr(CSR_DEBOUNCE_MS, 32'd0);
      send_req(REQ_SAMPLE, 8'hF3, 32'h0000_0100);
      send_req(REQ_SAMPLE, 8'hF3, 32'h0000_0101);
      send_req(REQ_SAMPLE, 8'h00, 32'h0000_0101);
      send_req(REQ_SAMPLE, 8'h80, 32'h8000_0000);
   endtask

   // Longest debounce time is only met by an elapsed time of all ones.
   task automatic test_extreme_registers();
      write_csr(CSR_DEBOUNCE_MS, 32'hFFFF_FFFF);
      write_csr(CSR_GUARD_MASK, 32'h0000_00FF);
      send_req(REQ_INIT,   8'h00, 32'd1);
      send_req(REQ_SAMPLE, 8'h20, 32'h10);
      send_req(REQ_SAMPLE, 8'h20, 32'h0F);
      send_req(REQ_SAMPLE, 8'h24, 32'h0E);
      send_req(REQ_SAMPLE, 8'h24, 32'h0D);
      write_csr(CSR_DEBOUNCE_MS, 32'd0);
      write_csr(CSR_GUARD_MASK, 32'd0);
      send_req(REQ_SAMPLE, 8'hFF, 32'd5);
      send_req(REQ_SAMPLE, 8'h00, 32'd5);
   endtask

   // The receiver holds off while requests keep coming, so req_ready must drop.
   task automatic test_backpressure();
      hold_left = 60;
      repeat (24) send_beat(next_sample(32'd3));
      wait_drained();
   endtask

   task automatic test_random_traffic(input int total);
      logic [CSR_W-1:0] dbc;
      logic [BTN_W-1:0] mask;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       dbc = 32'd0;
            1:       dbc = $urandom_range(1, 6);
            2:       dbc = DEBOUNCE_MS_RESET;
            3:       dbc = 32'hFFFF_FFFF;
            4:       dbc = $urandom;
            default: dbc = $urandom_range(2, 40);
         endcase
         if (phase == 1) begin
            mask = 8'hFF;
         end else if (phase == 2) begin
            mask = 8'h00;
         end else begin
            mask = BTN_W'($urandom_range(0, 255));
         end
         write_csr(CSR_DEBOUNCE_MS, dbc);
         write_csr(CSR_GUARD_MASK, CSR_W'(mask));
         stim_time = $urandom;
         for (int n = 0; n < total / 6; n++) begin
            send_beat(next_sample(dbc));
            // The reset-valued phase runs back to back on the sending side.
            if (phase != 2) begin
               pace_sender();
            end
         end
      end
   endtask

   initial begin : main
      int spin;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_init_and_wrap();
      test_zero_debounce_conflict();
      test_extreme_registers();
      test_backpressure();
      test_random_traffic(500);

      idle_cycles(1);
      for (spin = 0; spin < 5000 && pending_rsp.size() != 0; spin++) begin
         @(posedge clock);
      end
      if (pending_rsp.size() != 0) begin
         report_mismatch("responses never returned", 0, pending_rsp.size());
      end
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
